FILE: src/dmxq_pkg.sv
package dmxq_pkg;

	// Receive control states, as shown on the result beat
	typedef enum logic [1:0] {
		RX_BREAK_VALID = 2'd0,
		RX_RECEIVING   = 2'd1,
		RX_COMPLETE    = 2'd2,
		RX_ERROR       = 2'd3
	} rx_state_t;

	// Event kinds carried on the input tuser
	typedef enum logic [1:0] {
		CMD_LINE_EVENT = 2'd0,
		CMD_UART_ERROR = 2'd1,
		CMD_FRAME_DONE = 2'd2,
		CMD_SUPER_TICK = 2'd3
	} cmd_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_BREAK_THRESHOLD   = 2'd0;
	localparam logic [1:0] CFG_MARK_MINIMUM      = 2'd1;
	localparam logic [1:0] CFG_PACKET_RATE_LIMIT = 2'd2;
	localparam logic [1:0] CFG_ACTIVE_CHECKS     = 2'd3;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Reset values: 88 us minimum break less 40 us of UART framing latency
	localparam logic [15:0] BREAK_THRESHOLD_RST   = 16'd48;
	localparam logic [15:0] MARK_MINIMUM_RST      = 16'd8;
	localparam logic [7:0]  PACKET_RATE_LIMIT_RST = 8'd50;
	localparam logic [3:0]  ACTIVE_CHECKS_RST     = 4'd5;

	localparam logic [7:0] PACKET_COUNT_MAX = 8'd255;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] break_length;
		logic [15:0] mark_length;
	} item_t;

	typedef struct packed {
		rx_state_t  rx_state;
		logic       start_receive;
		logic       frame_valid;
		logic       signal_active;
		logic [3:0] check_level;
	} result_t;

endpackage

FILE: src/dmxq_in_stage.sv
module dmxq_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dmxq_pkg::item_t in_item,
	input  logic            down_ready,
	output logic            item_valid_s1,
	output dmxq_pkg::item_t item_s1
);

	// Refill whenever the held item leaves or the stage is empty
	assign in_ready = !item_valid_s1 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: src/dmxq_engine.sv
module dmxq_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dmxq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dmxq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                fire,
	input  dmxq_pkg::item_t                     item,
	output dmxq_pkg::result_t                   result
);

	logic [15:0] break_threshold_q;
	logic [15:0] mark_minimum_q;
	logic [7:0]  packet_rate_limit_q;
	logic [3:0]  active_checks_q;

	dmxq_pkg::rx_state_t rx_state_q, rx_state_d;
	logic [7:0]          packets_q, packets_d;
	logic [3:0]          check_q, check_d;
	logic                active_q, active_d;
	logic                start_d, fvalid_d;
	logic                tick_good;
	logic signed [5:0]   check_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_threshold_q   <= dmxq_pkg::BREAK_THRESHOLD_RST;
			mark_minimum_q      <= dmxq_pkg::MARK_MINIMUM_RST;
			packet_rate_limit_q <= dmxq_pkg::PACKET_RATE_LIMIT_RST;
			active_checks_q     <= dmxq_pkg::ACTIVE_CHECKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dmxq_pkg::CFG_BREAK_THRESHOLD:   break_threshold_q   <= cfg_wdata;
				dmxq_pkg::CFG_MARK_MINIMUM:      mark_minimum_q      <= cfg_wdata;
				dmxq_pkg::CFG_PACKET_RATE_LIMIT: packet_rate_limit_q <= cfg_wdata[7:0];
				dmxq_pkg::CFG_ACTIVE_CHECKS:     active_checks_q     <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign tick_good  = (packets_q != 8'd0) && (packets_q < packet_rate_limit_q);
	assign check_step = tick_good ? ($signed({2'b00, check_q}) + 6'sd1)
	                              : ($signed({2'b00, check_q}) - 6'sd1);

	always_comb begin
		rx_state_d = rx_state_q;
		packets_d  = packets_q;
		check_d    = check_q;
		active_d   = active_q;
		start_d    = 1'b0;
		fvalid_d   = 1'b0;
		case (item.cmd)
			dmxq_pkg::CMD_LINE_EVENT: begin
				if (item.break_length > break_threshold_q) begin
					if (item.mark_length < mark_minimum_q) begin
						rx_state_d = dmxq_pkg::RX_ERROR;
						packets_d  = 8'd0;
					end else begin
						rx_state_d = dmxq_pkg::RX_RECEIVING;
						start_d    = 1'b1;
						if (packets_q != dmxq_pkg::PACKET_COUNT_MAX) begin
							packets_d = packets_q + 8'd1;
						end
					end
				end
			end
			dmxq_pkg::CMD_UART_ERROR: begin
				rx_state_d = dmxq_pkg::RX_ERROR;
			end
			dmxq_pkg::CMD_FRAME_DONE: begin
				if (rx_state_q == dmxq_pkg::RX_RECEIVING) begin
					rx_state_d = dmxq_pkg::RX_COMPLETE;
					fvalid_d   = 1'b1;
				end
			end
			dmxq_pkg::CMD_SUPER_TICK: begin
				if (!tick_good) begin
					rx_state_d = dmxq_pkg::RX_ERROR;
				end
				// Saturate between zero and the active level
				if (check_step >= $signed({2'b00, active_checks_q})) begin
					check_d  = active_checks_q;
					active_d = 1'b1;
				end else if (check_step < 6'sd0) begin
					check_d  = 4'd0;
					active_d = 1'b0;
				end else begin
					check_d = check_step[3:0];
				end
				packets_d = 8'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_state_q <= dmxq_pkg::RX_ERROR;
			packets_q  <= 8'd0;
			check_q    <= 4'd0;
			active_q   <= 1'b0;
		end else if (fire) begin
			rx_state_q <= rx_state_d;
			packets_q  <= packets_d;
			check_q    <= check_d;
			active_q   <= active_d;
		end
	end

	always_comb begin
		result.rx_state      = rx_state_d;
		result.start_receive = start_d;
		result.frame_valid   = fvalid_d;
		result.signal_active = active_d;
		result.check_level   = check_d;
	end

endmodule

FILE: src/dmxq_out_stage.sv
module dmxq_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  dmxq_pkg::result_t result,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_ready,
	output dmxq_pkg::result_t result_s2
);

	logic valid_s2;

	assign can_load  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			result_s2 <= result;
		end
	end

endmodule

FILE: src/dmx_break_mab_signal_qualifier_core.sv
// DMX-512 break / mark-after-break qualifier, receive control of one line.
// Path: a beat accepted on s_axis waits in the input register, then moves
// into the result register and is offered on m_axis from there.
// Throughput: one event per cycle while no result beat is stalled on m_axis.
// Reset (arst_n low, asynchronous): receive state error, counters cleared,
// configuration registers back to their defaults, both channels empty.
module dmx_break_mab_signal_qualifier_core (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration: 0 break_threshold, 1 mark_minimum,
	// 2 packet_rate_limit, 3 active_checks
	input  logic                            cfg_we,
	input  logic [dmxq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dmxq_pkg::CFG_DATA_W-1:0] cfg_wdata,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] break_length, [31:16] mark_length
	input  logic [1:0]  s_axis_tuser,  // [1:0] cmd

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [1:0] rx_state, [2] start_receive,
	                                   // [3] frame_valid, [4] signal_active,
	                                   // [8:5] check_level, [15:9] zero
);

	dmxq_pkg::item_t   in_item;
	dmxq_pkg::item_t   item_s1;
	dmxq_pkg::result_t result;
	dmxq_pkg::result_t result_s2;
	logic              item_valid_s1;
	logic              can_load;
	logic              fire;

	// Unpack the incoming beat
	always_comb begin
		in_item.cmd          = dmxq_pkg::cmd_t'(s_axis_tuser);
		in_item.break_length = s_axis_tdata[15:0];
		in_item.mark_length  = s_axis_tdata[31:16];
	end

	// Hold the event here until the result register frees up
	dmxq_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_item      (in_item),
		.down_ready   (can_load),
		.item_valid_s1(item_valid_s1),
		.item_s1      (item_s1)
	);

	// An event is processed, and the state advances, only in the cycle its
	// result enters the output register; a stalled event leaves state alone.
	assign fire = item_valid_s1 && can_load;

	dmxq_engine u_eng (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fire     (fire),
		.item     (item_s1),
		.result   (result)
	);

	// Result register parts the two sides so input keeps flowing
	dmxq_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.result   (result),
		.can_load (can_load),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.result_s2(result_s2)
	);

	// Pack the result beat, lowest field first
	assign m_axis_tdata = {7'd0, result_s2.check_level, result_s2.signal_active,
	                       result_s2.frame_valid, result_s2.start_receive,
	                       result_s2.rx_state};

endmodule

FILE: src/dmxq_checker.sv
module dmxq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	logic out_stall;

	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// A stalled result beat stays offered
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload
	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> $stable(m_axis_tdata))
		else $error("result payload changed while stalled");

	// Start of reception always reports the receiving state
	a_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2]) |->
			(m_axis_tdata[1:0] == dmxq_pkg::RX_RECEIVING))
		else $error("start_receive without receiving state");

	// An accepted frame always reports the complete state
	a_frame_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[3]) |->
			(m_axis_tdata[1:0] == dmxq_pkg::RX_COMPLETE))
		else $error("frame_valid without complete state");

	// Unused result bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'd0))
		else $error("result padding not zero");

endmodule

bind dmx_break_mab_signal_qualifier_core dmxq_checker u_dmxq_checker (.*);

FILE: tb/sv/tb_dmx_break_mab_signal_qualifier_core.sv
module tb_dmx_break_mab_signal_qualifier_core;

	// Cycles with no beat on either side before the run is abandoned. The longest
	// correct quiet stretch comes from the forced receiver hold-off.
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [dmxq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dmxq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [15:0] break_length, [31:16] mark_length
	logic [1:0]  s_axis_tuser = '0;   // [1:0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [15:0] m_axis_tdata;        // [1:0] rx_state, [2] start_receive,
	                                  // [3] frame_valid, [4] signal_active, [8:5] check_level

	dmx_break_mab_signal_qualifier_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// Event queue feeding the driver, and results still owed by the block
	dmxq_pkg::item_t   pending_events[$];
	dmxq_pkg::result_t expected_results[$];

	// Shadow copy of the configuration registers
	logic [15:0] brk_thr    = dmxq_pkg::BREAK_THRESHOLD_RST;
	logic [15:0] mark_min   = dmxq_pkg::MARK_MINIMUM_RST;
	logic [7:0]  rate_lim   = dmxq_pkg::PACKET_RATE_LIMIT_RST;
	logic [3:0]  act_checks = dmxq_pkg::ACTIVE_CHECKS_RST;

	// Shadow copy of the receive control state
	dmxq_pkg::rx_state_t rx_st = dmxq_pkg::RX_ERROR;
	logic [7:0] pkt_count  = '0;
	logic [3:0] chk_level  = '0;
	logic       sig_active = 1'b0;

	// Traffic shaping, set per phase by the sequence below
	bit src_idle_en  = 1'b0;
	bit snk_stall_en = 1'b0;
	int idle_pct     = 58;
	bit hold_req     = 1'b0;
	bit hold_done    = 1'b0;
	int hold_left    = 0;

	int errors = 0;
	int quiet_cycles = 0;
	int n_queued = 0;
	int n_phases = 0;
	int n_events[4] = '{0, 0, 0, 0};
	int n_starts = 0;
	int n_frames = 0;
	int n_active = 0;

	task automatic report_mismatch(input string what);
		if (errors < 40)
			$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	// Apply one event to the shadow state and return the result the block owes
	function automatic dmxq_pkg::result_t qualify_event(input dmxq_pkg::item_t ev);
		dmxq_pkg::result_t res;
		logic signed [5:0] lvl;
		res = '0;
		case (ev.cmd)
		dmxq_pkg::CMD_LINE_EVENT: begin
			// a break not longer than the threshold is ignored
			if (ev.break_length > brk_thr) begin
				if (ev.mark_length < mark_min) begin
					rx_st = dmxq_pkg::RX_ERROR;
					pkt_count = '0;
				end else begin
					rx_st = dmxq_pkg::RX_RECEIVING;
					res.start_receive = 1'b1;
					if (pkt_count != dmxq_pkg::PACKET_COUNT_MAX)
						pkt_count = pkt_count + 8'd1;
				end
			end
		end
		dmxq_pkg::CMD_UART_ERROR: rx_st = dmxq_pkg::RX_ERROR;
		dmxq_pkg::CMD_FRAME_DONE: begin
			if (rx_st == dmxq_pkg::RX_RECEIVING) begin
				rx_st = dmxq_pkg::RX_COMPLETE;
				res.frame_valid = 1'b1;
			end
		end
		default: begin
			// supervisor tick: step the hysteresis counter, then clamp both ends
			lvl = $signed({2'b00, chk_level});
			if (pkt_count != 8'd0 && pkt_count < rate_lim) begin
				lvl = lvl + 6'sd1;
			end else begin
				lvl = lvl - 6'sd1;
				rx_st = dmxq_pkg::RX_ERROR;
			end
			if (lvl >= $signed({2'b00, act_checks})) begin
				lvl = $signed({2'b00, act_checks});
				sig_active = 1'b1;
			end
			if (lvl < 6'sd0) begin
				lvl = 6'sd0;
				sig_active = 1'b0;
			end
			chk_level = lvl[3:0];
			pkt_count = '0;
		end
		endcase
		res.rx_state      = rx_st;
		res.signal_active = sig_active;
		res.check_level   = chk_level;
		return res;
	endfunction

	// Driver: predict on every accepted beat, then offer the next event or idle
	always @(posedge clk) begin
		dmxq_pkg::item_t ev;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				ev.cmd          = dmxq_pkg::cmd_t'(s_axis_tuser);
				ev.break_length = s_axis_tdata[15:0];
				ev.mark_length  = s_axis_tdata[31:16];
				n_events[ev.cmd]++;
				expected_results.push_back(qualify_event(ev));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_events.size() != 0 &&
				    !(src_idle_en && $urandom_range(99) < idle_pct)) begin
					ev = pending_events.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {ev.mark_length, ev.break_length};
					s_axis_tuser  <= ev.cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result beat against the oldest prediction, drive tready
	always @(posedge clk) begin
		dmxq_pkg::result_t exp_r;
		dmxq_pkg::result_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.rx_state      = dmxq_pkg::rx_state_t'(m_axis_tdata[1:0]);
				got.start_receive = m_axis_tdata[2];
				got.frame_valid   = m_axis_tdata[3];
				got.signal_active = m_axis_tdata[4];
				got.check_level   = m_axis_tdata[8:5];
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result beat 0x%04h with nothing expected",
						m_axis_tdata));
				end else begin
					exp_r = expected_results.pop_front();
					if (got.rx_state != exp_r.rx_state)
						report_mismatch($sformatf("rx_state %s, expected %s",
							got.rx_state.name(), exp_r.rx_state.name()));
					if (got.start_receive != exp_r.start_receive)
						report_mismatch($sformatf("start_receive %0b, expected %0b",
							got.start_receive, exp_r.start_receive));
					if (got.frame_valid != exp_r.frame_valid)
						report_mismatch($sformatf("frame_valid %0b, expected %0b",
							got.frame_valid, exp_r.frame_valid));
					if (got.signal_active != exp_r.signal_active)
						report_mismatch($sformatf("signal_active %0b, expected %0b",
							got.signal_active, exp_r.signal_active));
					if (got.check_level != exp_r.check_level)
						report_mismatch($sformatf("check_level %0d, expected %0d",
							got.check_level, exp_r.check_level));
					n_starts += int'(exp_r.start_receive);
					n_frames += int'(exp_r.frame_valid);
					n_active += int'(exp_r.signal_active);
				end
			end
			// long hold-off once per request, so the block backs up into its input
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !(snk_stall_en && $urandom_range(99) < idle_pct);
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic push_event(input dmxq_pkg::cmd_t c, input logic [15:0] brk,
	                          input logic [15:0] mark);
		dmxq_pkg::item_t ev;
		ev.cmd = c;
		ev.break_length = brk;
		ev.mark_length = mark;
		pending_events.push_back(ev);
		n_queued++;
	endtask

	// Write one register while the block is idle and mirror it
	task automatic set_reg(input logic [dmxq_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
		dmxq_pkg::CFG_BREAK_THRESHOLD:   brk_thr    = val;
		dmxq_pkg::CFG_MARK_MINIMUM:      mark_min   = val;
		dmxq_pkg::CFG_PACKET_RATE_LIMIT: rate_lim   = val[7:0];
		default:                         act_checks = val[3:0];
		endcase
	endtask

	task automatic set_all(input logic [15:0] thr, input logic [15:0] mmin,
	                       input logic [7:0] lim, input logic [3:0] chk);
		set_reg(dmxq_pkg::CFG_BREAK_THRESHOLD, thr);
		set_reg(dmxq_pkg::CFG_MARK_MINIMUM, mmin);
		set_reg(dmxq_pkg::CFG_PACKET_RATE_LIMIT, {8'd0, lim});
		set_reg(dmxq_pkg::CFG_ACTIVE_CHECKS, {12'd0, chk});
		n_phases++;
	endtask

	// Wait until every event is taken and every result has come back
	task automatic drain();
		while (pending_events.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Any 16-bit value
	function automatic logic [15:0] any16();
		return 16'($urandom_range(65535));
	endfunction

	// Break lengths that pass or fail the threshold, half of them near the edge
	function automatic logic [15:0] long_break();
		int lo;
		if (brk_thr == 16'hFFFF)
			return 16'($urandom_range(65535));
		lo = brk_thr + 1;
		if ($urandom_range(1))
			return 16'($urandom_range(lo, (lo + 300 > 65535) ? 65535 : lo + 300));
		return 16'($urandom_range(65535, lo));
	endfunction

	function automatic logic [15:0] short_break();
		if ($urandom_range(1))
			return 16'(brk_thr - $urandom_range(brk_thr < 20 ? brk_thr : 20));
		return 16'($urandom_range(brk_thr));
	endfunction

	function automatic logic [15:0] good_mark();
		if ($urandom_range(1))
			return (mark_min > 65435) ? mark_min : 16'(mark_min + $urandom_range(100));
		return 16'($urandom_range(65535, mark_min));
	endfunction

	function automatic logic [15:0] short_mark();
		if (mark_min == 16'd0)
			return good_mark();
		return 16'($urandom_range(mark_min - 1));
	endfunction

	// n frame attempts, mostly well formed, some broken or noise
	task automatic push_frames(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 80) begin
				push_event(dmxq_pkg::CMD_LINE_EVENT, long_break(), good_mark());
				if ($urandom_range(99) < 85)
					push_event(dmxq_pkg::CMD_FRAME_DONE, any16(), any16());
			end else if (r < 86) begin
				push_event(dmxq_pkg::CMD_LINE_EVENT, short_break(), any16());
			end else if (r < 91) begin
				push_event(dmxq_pkg::CMD_LINE_EVENT, long_break(), short_mark());
			end else if (r < 95) begin
				push_event(dmxq_pkg::CMD_UART_ERROR, any16(), any16());
			end else if (r < 98) begin
				push_event(dmxq_pkg::CMD_LINE_EVENT, any16(), any16());
			end else begin
				push_event(dmxq_pkg::CMD_FRAME_DONE, any16(), any16());
			end
		end
	endtask

	// Tick-separated bursts: mostly a good packet count, sometimes none or too many
	task automatic push_random(input int count);
		int first;
		int n;
		int r;
		first = n_queued;
		while (n_queued - first < count) begin
			r = $urandom_range(99);
			if (r < 75)
				n = $urandom_range(1, (rate_lim > 7) ? 6 : ((rate_lim > 1) ? rate_lim - 1 : 1));
			else if (r < 85)
				n = 0;
			else
				n = (rate_lim <= 20) ? rate_lim + $urandom_range(3) : $urandom_range(1, 3);
			push_frames(n);
			push_event(dmxq_pkg::CMD_SUPER_TICK, any16(), any16());
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Defaults after reset, no idling: directed corner cases
		n_phases = 1;
		push_event(dmxq_pkg::CMD_FRAME_DONE, 16'h0000, 16'h0000); // frame done outside reception
		push_event(dmxq_pkg::CMD_SUPER_TICK, 16'hFFFF, 16'hFFFF); // tick with no packets at floor
		push_event(dmxq_pkg::CMD_LINE_EVENT, 16'd48, 16'hFFFF);   // break equal to threshold
		push_event(dmxq_pkg::CMD_LINE_EVENT, 16'd49, 16'd7);      // mark one short
		push_event(dmxq_pkg::CMD_LINE_EVENT, 16'd49, 16'd8);      // shortest good break and mark
		push_event(dmxq_pkg::CMD_FRAME_DONE, 16'hFFFF, 16'h0000); // frame accepted
		push_event(dmxq_pkg::CMD_FRAME_DONE, 16'h0000, 16'hFFFF); // already complete
		push_event(dmxq_pkg::CMD_UART_ERROR, 16'hA5A5, 16'h5A5A);
		push_event(dmxq_pkg::CMD_LINE_EVENT, 16'hFFFF, 16'hFFFF);
		push_event(dmxq_pkg::CMD_LINE_EVENT, 16'h0000, 16'h0000);
		push_event(dmxq_pkg::CMD_LINE_EVENT, 16'hFFFF, 16'h0000); // short mark clears the count
		repeat (6) begin                                           // climb to the top and stay
			push_event(dmxq_pkg::CMD_LINE_EVENT, 16'd100, 16'd20);
			push_event(dmxq_pkg::CMD_SUPER_TICK, 16'h0000, 16'h0000);
		end
		push_event(dmxq_pkg::CMD_SUPER_TICK, 16'h0000, 16'h0000); // bad tick steps down
		drain();

		// Loosest break checks, tiny rate limit, sender idling
		set_all(16'd0, 16'd0, 8'd2, 4'd1);
		src_idle_en = 1'b1;
		push_random(300);
		drain();

		// Nothing can qualify: strictest break checks, every tick bad
		set_all(16'hFFFF, 16'hFFFF, 8'd1, 4'd15);
		src_idle_en = 1'b0;
		snk_stall_en = 1'b1;
		push_random(150);
		drain();

		// Widest rate limit: saturate the packet count, then random traffic
		set_all(16'd1000, 16'd100, 8'd255, 4'd15);
		src_idle_en = 1'b1;
		push_frames(0);
		repeat (260)
			push_event(dmxq_pkg::CMD_LINE_EVENT, long_break(), good_mark());
		push_event(dmxq_pkg::CMD_SUPER_TICK, 16'h0000, 16'h0000);
		push_random(400);
		drain();

		// Lower the top below the current level; back up the output with a hold-off
		set_all(any16(), 16'($urandom_range(300)), 8'd8, 4'd3);
		src_idle_en = 1'b0;
		snk_stall_en = 1'b0;
		hold_req = 1'b1;
		push_random(350);
		drain();

		// Back to the default settings with both sides idling
		set_all(dmxq_pkg::BREAK_THRESHOLD_RST, dmxq_pkg::MARK_MINIMUM_RST,
		        dmxq_pkg::PACKET_RATE_LIMIT_RST, dmxq_pkg::ACTIVE_CHECKS_RST);
		src_idle_en = 1'b1;
		snk_stall_en = 1'b1;
		idle_pct = 32;
		push_random(300);
		drain();

		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		$display("covered %0d line events, %0d uart errors, %0d frame done, %0d ticks in %0d settings",
			n_events[dmxq_pkg::CMD_LINE_EVENT], n_events[dmxq_pkg::CMD_UART_ERROR],
			n_events[dmxq_pkg::CMD_FRAME_DONE], n_events[dmxq_pkg::CMD_SUPER_TICK], n_phases);
		$display("saw %0d receptions started, %0d frames accepted, %0d results with signal active",
			n_starts, n_frames, n_active);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/dmxq_pkg.sv
src/dmxq_in_stage.sv
src/dmxq_engine.sv
src/dmxq_out_stage.sv
src/dmx_break_mab_signal_qualifier_core.sv
src/dmxq_checker.sv
tb/sv/tb_dmx_break_mab_signal_qualifier_core.sv
